[rtl/compute_node_resource_allocator_defines.svh]
// assertion macros shared by the compute node resource allocator
`ifndef COMPUTE_NODE_RESOURCE_ALLOCATOR_DEFINES_SVH
`define COMPUTE_NODE_RESOURCE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define CNRA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("cnra assertion failed");

// next-cycle implication, disabled while reset is asserted
`define CNRA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("cnra assertion failed");

`endif

[rtl/cnra_pkg.sv]
// types, codes and constants of the compute node resource allocator
`default_nettype none

package cnra_pkg;

  localparam int MAX_CORES_DEF = 64;
  localparam int TIME_BITS_DEF = 32;

  localparam int USAGE_W = 40;
  localparam logic [USAGE_W-1:0] USAGE_MAX = {USAGE_W{1'b1}};

  localparam logic [6:0]  RST_TOTAL_CORES  = 7'd64;
  localparam logic [31:0] RST_TOTAL_MEMORY = 32'd65536;
  localparam logic [31:0] RST_TOTAL_DISK   = 32'd1048576;
  localparam logic [6:0]  RST_MAX_SLOTS    = 7'd1;

  typedef enum logic [1:0] {
    REQ_ALLOC    = 2'd0,
    REQ_REL_TOT  = 2'd1,
    REQ_REL_CORE = 2'd2,
    REQ_NONE     = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_GRANTED  = 2'd0,
    ST_NO_SLOT  = 2'd1,
    ST_SHORT    = 2'd2,
    ST_RELEASED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_TOTAL_CORES  = 2'd0,
    CFG_TOTAL_MEMORY = 2'd1,
    CFG_TOTAL_DISK   = 2'd2,
    CFG_MAX_SLOTS    = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_CHK,
    S_SCAN,
    S_REL_TOT,
    S_RC_READ,
    S_RC_ELAPSE,
    S_RC_UPDATE
  } state_e;

  typedef struct packed {
    req_type_e   req_type;
    logic [6:0]  core_count;
    logic [31:0] memory_amount;
    logic [31:0] disk_amount;
    logic [5:0]  core_index;
    logic [31:0] now_seconds;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [5:0]         granted_core;
    logic               core_valid;
    logic [USAGE_W-1:0] usage_seconds;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic    capture;
    logic    emit_simple;
    status_e simple_status;
    logic    alloc_commit;
    logic    scan_step;
    logic    scan_finish;
    logic    rel_totals;
    logic    rc_read;
    logic    rc_elapse;
    logic    rc_update;
  } cmd_t;

  typedef struct packed {
    logic no_slot;
    logic res_short;
    logic scan_more;
    logic idx_oor;
  } sts_t;

endpackage

`default_nettype wire

[rtl/cnra_ctrl.sv]
// request sequencer of the compute node resource allocator
`default_nettype none

module cnra_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire cnra_pkg::req_type_e req_type_i,
  input  wire cnra_pkg::sts_t     sts_i,
  output cnra_pkg::cmd_t          cmd_o,
  output logic                    busy_o
);

  cnra_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cnra_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.simple_status = cnra_pkg::ST_RELEASED;
    unique case (state_q)
      cnra_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          unique case (req_type_i)
            cnra_pkg::REQ_ALLOC:    state_d = cnra_pkg::S_ALLOC_CHK;
            cnra_pkg::REQ_REL_TOT:  state_d = cnra_pkg::S_REL_TOT;
            cnra_pkg::REQ_REL_CORE: state_d = cnra_pkg::S_RC_READ;
            default:                state_d = cnra_pkg::S_IDLE;
          endcase
        end
      end
      cnra_pkg::S_ALLOC_CHK: begin
        if (sts_i.no_slot) begin
          cmd_o.emit_simple   = 1'b1;
          cmd_o.simple_status = cnra_pkg::ST_NO_SLOT;
          state_d = cnra_pkg::S_IDLE;
        end else if (sts_i.res_short) begin
          cmd_o.emit_simple   = 1'b1;
          cmd_o.simple_status = cnra_pkg::ST_SHORT;
          state_d = cnra_pkg::S_IDLE;
        end else begin
          cmd_o.alloc_commit = 1'b1;
          state_d = cnra_pkg::S_SCAN;
        end
      end
      cnra_pkg::S_SCAN: begin
        if (sts_i.scan_more) begin
          cmd_o.scan_step = 1'b1;
        end else begin
          cmd_o.scan_finish = 1'b1;
          state_d = cnra_pkg::S_IDLE;
        end
      end
      cnra_pkg::S_REL_TOT: begin
        cmd_o.rel_totals  = 1'b1;
        cmd_o.emit_simple = 1'b1;
        state_d = cnra_pkg::S_IDLE;
      end
      cnra_pkg::S_RC_READ: begin
        if (sts_i.idx_oor) begin
          cmd_o.emit_simple = 1'b1;
          state_d = cnra_pkg::S_IDLE;
        end else begin
          cmd_o.rc_read = 1'b1;
          state_d = cnra_pkg::S_RC_ELAPSE;
        end
      end
      cnra_pkg::S_RC_ELAPSE: begin
        cmd_o.rc_elapse = 1'b1;
        state_d = cnra_pkg::S_RC_UPDATE;
      end
      cnra_pkg::S_RC_UPDATE: begin
        cmd_o.rc_update = 1'b1;
        state_d = cnra_pkg::S_IDLE;
      end
      default: begin
        state_d = cnra_pkg::S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != cnra_pkg::S_IDLE);

endmodule

`default_nettype wire

[rtl/cnra_dp.sv]
// counters, free map, per-core time memories and result register
`default_nettype none

module cnra_dp #(
  parameter int MAX_CORES = cnra_pkg::MAX_CORES_DEF,
  parameter int TIME_BITS = cnra_pkg::TIME_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire cnra_pkg::cfg_idx_e cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire cnra_pkg::req_t     req_i,
  input  wire cnra_pkg::cmd_t     cmd_i,
  output cnra_pkg::sts_t          sts_o,
  output logic                    result_valid_o,
  output cnra_pkg::rsp_t          rsp_o
);

  localparam int IW   = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int JW   = $clog2(MAX_CORES + 1);
  localparam int CMPW = (JW > 7) ? JW : 7;
  localparam int UW   = cnra_pkg::USAGE_W;
  localparam int SW   = ((TIME_BITS > UW) ? TIME_BITS : UW) + 1;
  localparam logic [6:0] LIM_RST =
    (MAX_CORES < 64) ? 7'(MAX_CORES) : cnra_pkg::RST_TOTAL_CORES;

  // configuration and running counters
  logic [6:0]  lim_q, lim_d;
  logic [31:0] total_mem_q, total_mem_d;
  logic [31:0] total_disk_q, total_disk_d;
  logic [6:0]  max_slots_q, max_slots_d;
  logic [6:0]  free_cores_q, free_cores_d;
  logic [31:0] free_mem_q, free_mem_d;
  logic [31:0] free_disk_q, free_disk_d;
  logic [6:0]  free_slots_q, free_slots_d;

  logic [MAX_CORES-1:0] map_q, map_d;
  logic [MAX_CORES-1:0] uvld_q, uvld_d;

  // captured request
  logic [6:0]           count_q, count_d;
  logic [31:0]          mem_amt_q, mem_amt_d;
  logic [31:0]          disk_amt_q, disk_amt_d;
  logic [5:0]           idx_q, idx_d;
  logic [TIME_BITS-1:0] now_q, now_d;

  // scan
  logic [JW-1:0] j_q, j_d;
  logic [6:0]    n_q, n_d;
  logic          pend_q, pend_d;
  logic [IW-1:0] pend_core_q, pend_core_d;
  logic [IW-1:0] j_idx;
  logic          hit;

  // release-core
  logic [TIME_BITS-1:0] start_rd_q;
  logic [UW-1:0]        usage_rd_q;
  logic                 uvld_rd_q, uvld_rd_d;
  logic                 busy_rd_q, busy_rd_d;
  logic [TIME_BITS-1:0] el_q, el_d;
  logic [UW-1:0]        u_q, u_d;
  logic [SW-1:0]        usage_sum;
  logic [UW-1:0]        new_usage;
  logic [IW-1:0]        rc_addr;

  logic [TIME_BITS-1:0] start_mem [MAX_CORES];
  logic [UW-1:0]        usage_mem [MAX_CORES];

  logic                 out_valid_q, out_valid_d;
  cnra_pkg::rsp_t       out_q, out_d;

  logic [6:0] lim_cfg;
  logic [7:0] slot_sum, core_sum;
  logic [32:0] mem_sum, disk_sum;

  assign j_idx   = j_q[IW-1:0];
  assign hit     = map_q[j_idx];
  assign rc_addr = IW'(idx_q);

  assign lim_cfg = (32'(cfg_data_i[6:0]) > 32'(MAX_CORES)) ? 7'(MAX_CORES)
                                                            : cfg_data_i[6:0];

  assign slot_sum = {1'b0, free_slots_q} + 8'd1;
  assign core_sum = {1'b0, free_cores_q} + {1'b0, count_q};
  assign mem_sum  = {1'b0, free_mem_q} + {1'b0, mem_amt_q};
  assign disk_sum = {1'b0, free_disk_q} + {1'b0, disk_amt_q};

  assign usage_sum = SW'(u_q) + SW'(el_q);
  assign new_usage = (usage_sum > SW'(cnra_pkg::USAGE_MAX)) ? cnra_pkg::USAGE_MAX
                                                             : usage_sum[UW-1:0];

  assign sts_o.no_slot   = (free_slots_q == 7'd0);
  assign sts_o.res_short = (mem_amt_q > free_mem_q) || (disk_amt_q > free_disk_q) ||
                           (count_q > free_cores_q);
  assign sts_o.scan_more = (CMPW'(j_q) < CMPW'(lim_q)) && (n_q < count_q);
  assign sts_o.idx_oor   = (32'(idx_q) >= 32'(MAX_CORES));

  always_comb begin
    lim_d        = lim_q;
    total_mem_d  = total_mem_q;
    total_disk_d = total_disk_q;
    max_slots_d  = max_slots_q;
    free_cores_d = free_cores_q;
    free_mem_d   = free_mem_q;
    free_disk_d  = free_disk_q;
    free_slots_d = free_slots_q;
    map_d        = map_q;
    uvld_d       = uvld_q;
    count_d      = count_q;
    mem_amt_d    = mem_amt_q;
    disk_amt_d   = disk_amt_q;
    idx_d        = idx_q;
    now_d        = now_q;
    j_d          = j_q;
    n_d          = n_q;
    pend_d       = pend_q;
    pend_core_d  = pend_core_q;
    uvld_rd_d    = uvld_rd_q;
    busy_rd_d    = busy_rd_q;
    el_d         = el_q;
    u_d          = u_q;
    out_valid_d  = 1'b0;
    out_d        = out_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cnra_pkg::CFG_TOTAL_CORES: begin
          lim_d        = lim_cfg;
          free_cores_d = lim_cfg;
        end
        cnra_pkg::CFG_TOTAL_MEMORY: begin
          total_mem_d = cfg_data_i;
          free_mem_d  = cfg_data_i;
        end
        cnra_pkg::CFG_TOTAL_DISK: begin
          total_disk_d = cfg_data_i;
          free_disk_d  = cfg_data_i;
        end
        cnra_pkg::CFG_MAX_SLOTS: begin
          max_slots_d  = cfg_data_i[6:0];
          free_slots_d = cfg_data_i[6:0];
        end
        default: ;
      endcase
    end

    if (cmd_i.capture) begin
      count_d    = req_i.core_count;
      mem_amt_d  = req_i.memory_amount;
      disk_amt_d = req_i.disk_amount;
      idx_d      = req_i.core_index;
      now_d      = TIME_BITS'(req_i.now_seconds);
    end

    if (cmd_i.emit_simple) begin
      out_valid_d         = 1'b1;
      out_d               = '0;
      out_d.status        = cmd_i.simple_status;
      out_d.last          = 1'b1;
    end

    if (cmd_i.alloc_commit) begin
      free_cores_d = free_cores_q - count_q;
      free_mem_d   = free_mem_q - mem_amt_q;
      free_disk_d  = free_disk_q - disk_amt_q;
      free_slots_d = free_slots_q - 7'd1;
      j_d          = '0;
      n_d          = '0;
      pend_d       = 1'b0;
    end

    // a found core is held back until the next one is found so the final one can carry last
    if (cmd_i.scan_step) begin
      j_d = j_q + JW'(1);
      if (hit) begin
        map_d[j_idx] = 1'b0;
        n_d          = n_q + 7'd1;
        pend_d       = 1'b1;
        pend_core_d  = j_idx;
        if (pend_q) begin
          out_valid_d        = 1'b1;
          out_d              = '0;
          out_d.status       = cnra_pkg::ST_GRANTED;
          out_d.granted_core = 6'(pend_core_q);
          out_d.core_valid   = 1'b1;
        end
      end
    end

    if (cmd_i.scan_finish) begin
      out_valid_d        = 1'b1;
      out_d              = '0;
      out_d.status       = cnra_pkg::ST_GRANTED;
      out_d.granted_core = pend_q ? 6'(pend_core_q) : 6'd0;
      out_d.core_valid   = pend_q;
      out_d.last         = 1'b1;
    end

    if (cmd_i.rel_totals) begin
      free_slots_d = (slot_sum > {1'b0, max_slots_q}) ? max_slots_q : slot_sum[6:0];
      free_mem_d   = (mem_sum > {1'b0, total_mem_q}) ? total_mem_q : mem_sum[31:0];
      free_disk_d  = (disk_sum > {1'b0, total_disk_q}) ? total_disk_q : disk_sum[31:0];
      free_cores_d = (core_sum > {1'b0, lim_q}) ? lim_q : core_sum[6:0];
    end

    if (cmd_i.rc_read) begin
      uvld_rd_d = uvld_q[rc_addr];
      busy_rd_d = !map_q[rc_addr];
    end

    if (cmd_i.rc_elapse) begin
      el_d = now_q - start_rd_q;
      u_d  = uvld_rd_q ? usage_rd_q : '0;
    end

    if (cmd_i.rc_update) begin
      out_valid_d         = 1'b1;
      out_d               = '0;
      out_d.status        = cnra_pkg::ST_RELEASED;
      out_d.usage_seconds = busy_rd_q ? new_usage : u_q;
      out_d.last          = 1'b1;
      if (busy_rd_q) begin
        map_d[rc_addr]  = 1'b1;
        uvld_d[rc_addr] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q        <= LIM_RST;
      total_mem_q  <= cnra_pkg::RST_TOTAL_MEMORY;
      total_disk_q <= cnra_pkg::RST_TOTAL_DISK;
      max_slots_q  <= cnra_pkg::RST_MAX_SLOTS;
      free_cores_q <= LIM_RST;
      free_mem_q   <= cnra_pkg::RST_TOTAL_MEMORY;
      free_disk_q  <= cnra_pkg::RST_TOTAL_DISK;
      free_slots_q <= cnra_pkg::RST_MAX_SLOTS;
      map_q        <= '1;
      uvld_q       <= '0;
      pend_q       <= 1'b0;
      j_q          <= '0;
      n_q          <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      lim_q        <= lim_d;
      total_mem_q  <= total_mem_d;
      total_disk_q <= total_disk_d;
      max_slots_q  <= max_slots_d;
      free_cores_q <= free_cores_d;
      free_mem_q   <= free_mem_d;
      free_disk_q  <= free_disk_d;
      free_slots_q <= free_slots_d;
      map_q        <= map_d;
      uvld_q       <= uvld_d;
      pend_q       <= pend_d;
      j_q          <= j_d;
      n_q          <= n_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q     <= count_d;
    mem_amt_q   <= mem_amt_d;
    disk_amt_q  <= disk_amt_d;
    idx_q       <= idx_d;
    now_q       <= now_d;
    pend_core_q <= pend_core_d;
    uvld_rd_q   <= uvld_rd_d;
    busy_rd_q   <= busy_rd_d;
    el_q        <= el_d;
    u_q         <= u_d;
    out_q       <= out_d;
  end

  // start time memory: written by the scan, read by release-core
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step && hit) begin
      start_mem[j_idx] <= now_q;
    end
    if (cmd_i.rc_read) begin
      start_rd_q <= start_mem[rc_addr];
    end
  end

  // usage memory: entries without a valid bit read as zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.rc_update && busy_rd_q) begin
      usage_mem[rc_addr] <= new_usage;
    end
    if (cmd_i.rc_read) begin
      usage_rd_q <= usage_mem[rc_addr];
    end
  end

  assign result_valid_o = out_valid_q;
  assign rsp_o          = out_q;

endmodule

`default_nettype wire

[rtl/compute_node_resource_allocator.sv]
// top level of the compute node resource allocator
`default_nettype none
`include "compute_node_resource_allocator_defines.svh"

// usage: pulse start_i with a request on req_i while busy_o is low; the
//   transaction is taken at that clock edge and busy_o rises the cycle after
// results come out on rsp_o, one per cycle while result_valid_o is high, with
//   last set on the final one; the receiver cannot stall, every result is a
//   one-cycle strobe
// allocate: a check state, then the free map is scanned one core per cycle
//   over min(total_cores, MAX_CORES) cores, stopping once enough cores are
//   found; each grant is held back until the next core is found so the
//   last can be marked; the final result, with last set, is put out when
//   the scan ends
// refused allocate and release-totals give their single result from the
//   check or release state; release-core steps through time memory read,
//   elapsed time and saturating usage add
// request type 3 is dropped and gives no result
// configuration writes on cfg_we_i/cfg_idx_i/cfg_data_i land in the next
//   cycle and are only legal while busy_o is low and no result is pending
// reset: every core free, usage zero, counters and totals at their defaults;
//   no clearing pass is needed (usage entries carry valid bits)

module compute_node_resource_allocator #(
  parameter int MAX_CORES = cnra_pkg::MAX_CORES_DEF,
  parameter int TIME_BITS = cnra_pkg::TIME_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // request side
  input  wire logic               start_i,
  input  wire cnra_pkg::req_t     req_i,
  output logic                    busy_o,
  // result side
  output logic                    result_valid_o,
  output cnra_pkg::rsp_t          rsp_o,
  // configuration write port
  input  wire logic               cfg_we_i,
  input  wire cnra_pkg::cfg_idx_e cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i
);

  cnra_pkg::cmd_t cmd;
  cnra_pkg::sts_t sts;

  // helper terms for the checks below
  logic take_real;
  logic core_carried;
  logic core_rsp_ok;

  // sequencer: one request at a time
  cnra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_i.req_type),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy_o)
  );

  // counters, free map, time memories and the result register
  cnra_dp #(
    .MAX_CORES (MAX_CORES),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .req_i          (req_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

  assign take_real    = start_i && !busy_o && (req_i.req_type != cnra_pkg::REQ_NONE);
  assign core_carried = result_valid_o && rsp_o.core_valid;
  assign core_rsp_ok  = (rsp_o.status == cnra_pkg::ST_GRANTED) &&
                        (rsp_o.usage_seconds == '0);

  // a result is only produced from a working state
  `CNRA_ASSERT_IMP(a_result_after_busy, clk_i, rst_ni, result_valid_o, $past(busy_o))

  // a taken transaction of a real type keeps the block busy the next cycle
  `CNRA_ASSERT_NXT(a_start_busy, clk_i, rst_ni, take_real, busy_o)

  // nothing follows the final result of a transaction
  `CNRA_ASSERT_NXT(a_last_ends, clk_i, rst_ni, result_valid_o && rsp_o.last, !result_valid_o)

  // a carried core only appears on a granted allocate
  `CNRA_ASSERT_IMP(a_core_granted, clk_i, rst_ni, core_carried, core_rsp_ok)

endmodule

`default_nettype wire

[test/tb_top.sv]
// self-checking testbench for the compute node resource allocator
`timescale 1ns / 100ps

module tb_top;

  localparam int NCORES       = cnra_pkg::MAX_CORES_DEF;
  // random transactions after the directed part, unused type included
  localparam int RANDOM_ITEMS = 400;
  // settling wait in wait_drained, sized for the longest transaction, a full allocate
  localparam int LATENCY      = 70;
  localparam int CYCLE_LIMIT  = 500_000;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #2 clk_i = ~clk_i;

  // request side
  logic           start_i = 1'b0;
  cnra_pkg::req_t req_i   = '0;
  logic           busy_o;

  // result side
  logic           result_valid_o;
  cnra_pkg::rsp_t rsp_o;

  // configuration port
  logic               cfg_we_i   = 1'b0;
  cnra_pkg::cfg_idx_e cfg_idx_i  = cnra_pkg::CFG_TOTAL_CORES;
  logic [31:0]        cfg_data_i = '0;

  compute_node_resource_allocator DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .req_i          (req_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  // requests waiting to be driven, and results still owed by the block
  cnra_pkg::req_t pending_req_q[$];
  cnra_pkg::rsp_t awaited_rsp_q[$];

  int   error_cnt = 0;
  int   cycle_cnt = 0;
  logic steady    = 1'b0;  // set: sender never idles

  // ---------------------------------------------------------------------
  // node bookkeeping mirrored on the testbench side
  // ---------------------------------------------------------------------
  logic [6:0]  tot_cores, free_cores, tot_slots, free_slots;
  logic [31:0] tot_mem, free_mem, tot_disk, free_disk;
  logic        core_free  [NCORES];
  logic [31:0] core_stamp [NCORES];
  logic [39:0] core_usage [NCORES];

  function automatic logic [6:0] core_span();
    return (tot_cores > NCORES) ? 7'(NCORES) : tot_cores;
  endfunction

  // release adds stop at the configured total
  function automatic logic [31:0] add_capped(logic [31:0] a, logic [31:0] b,
                                             logic [31:0] top);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, top}) ? top : s[31:0];
  endfunction

  // a register write also refills the matching free counter
  function automatic void load_totals(cnra_pkg::cfg_idx_e idx, logic [31:0] val);
    case (idx)
      cnra_pkg::CFG_TOTAL_CORES: begin
        tot_cores  = val[6:0];
        free_cores = core_span();
      end
      cnra_pkg::CFG_TOTAL_MEMORY: begin
        tot_mem  = val;
        free_mem = val;
      end
      cnra_pkg::CFG_TOTAL_DISK: begin
        tot_disk  = val;
        free_disk = val;
      end
      cnra_pkg::CFG_MAX_SLOTS: begin
        tot_slots  = val[6:0];
        free_slots = val[6:0];
      end
      default: ;
    endcase
  endfunction

  // works out the results of one accepted transaction and queues them
  function automatic void serve_request(cnra_pkg::req_t r);
    cnra_pkg::rsp_t o;
    int unsigned    j, avail, grant_n, found;
    logic [31:0]    elapsed;
    o = '0;
    o.last = 1'b1;
    case (r.req_type)
      cnra_pkg::REQ_ALLOC: begin
        if (free_slots == 0) begin
          o.status = cnra_pkg::ST_NO_SLOT;
          awaited_rsp_q.push_back(o);
        end else if (r.memory_amount > free_mem || r.disk_amount > free_disk ||
                     r.core_count > free_cores) begin
          o.status = cnra_pkg::ST_SHORT;
          awaited_rsp_q.push_back(o);
        end else begin
          // the map may hold fewer free cores than the counter claims
          avail = 0;
          for (j = 0; j < core_span(); j++)
            if (core_free[j]) avail++;
          grant_n = (avail < r.core_count) ? avail : r.core_count;
          found = 0;
          for (j = 0; j < core_span() && found < grant_n; j++) begin
            if (core_free[j]) begin
              core_free[j]   = 1'b0;
              core_stamp[j]  = r.now_seconds;
              o              = '0;
              o.status       = cnra_pkg::ST_GRANTED;
              o.granted_core = 6'(j);
              o.core_valid   = 1'b1;
              o.last         = (found == grant_n - 1);
              awaited_rsp_q.push_back(o);
              found++;
            end
          end
          free_cores = free_cores - r.core_count;
          free_mem   = free_mem - r.memory_amount;
          free_disk  = free_disk - r.disk_amount;
          free_slots = free_slots - 7'd1;
          // granted but nothing taken from the map
          if (grant_n == 0) begin
            o.status = cnra_pkg::ST_GRANTED;
            awaited_rsp_q.push_back(o);
          end
        end
      end
      cnra_pkg::REQ_REL_TOT: begin
        free_slots = 7'(add_capped(32'(free_slots), 32'd1, 32'(tot_slots)));
        free_mem   = add_capped(free_mem, r.memory_amount, tot_mem);
        free_disk  = add_capped(free_disk, r.disk_amount, tot_disk);
        free_cores = 7'(add_capped(32'(free_cores), 32'(r.core_count),
                                   32'(core_span())));
        o.status = cnra_pkg::ST_RELEASED;
        awaited_rsp_q.push_back(o);
      end
      cnra_pkg::REQ_REL_CORE: begin
        // a core that is already free reports its usage untouched
        if (!core_free[r.core_index]) begin
          elapsed = r.now_seconds - core_stamp[r.core_index];
          if ({8'd0, elapsed} > cnra_pkg::USAGE_MAX - core_usage[r.core_index])
            core_usage[r.core_index] = cnra_pkg::USAGE_MAX;
          else
            core_usage[r.core_index] = core_usage[r.core_index] + {8'd0, elapsed};
          core_free[r.core_index] = 1'b1;
        end
        o.status        = cnra_pkg::ST_RELEASED;
        o.usage_seconds = core_usage[r.core_index];
        awaited_rsp_q.push_back(o);
      end
      default: ;  // unused type is dropped silently
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // driver: one transaction per start, back to back unless idling
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      req_i   <= '0;
    end else if (start_i && !busy_o) begin
      // transaction taken at this edge
      serve_request(req_i);
      if (pending_req_q.size() != 0 && (steady || $urandom_range(0, 99) >= 18)) begin
        req_i <= pending_req_q.pop_front();
      end else begin
        start_i <= 1'b0;
      end
    end else if (!start_i && pending_req_q.size() != 0 &&
                 (steady || $urandom_range(0, 99) >= 18)) begin
      start_i <= 1'b1;
      req_i   <= pending_req_q.pop_front();
    end
  end

  // ---------------------------------------------------------------------
  // monitor: every strobe must match the oldest owed result
  // ---------------------------------------------------------------------
  function automatic void check_field(string name, logic [39:0] want, logic [39:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      error_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    cnra_pkg::rsp_t want;
    if (rst_ni && result_valid_o) begin
      if (awaited_rsp_q.size() == 0) begin
        $error("result with nothing owed: status %0d core %0d", rsp_o.status,
               rsp_o.granted_core);
        error_cnt++;
      end else begin
        want = awaited_rsp_q.pop_front();
        check_field("status", 40'(want.status), 40'(rsp_o.status));
        check_field("granted_core", 40'(want.granted_core), 40'(rsp_o.granted_core));
        check_field("core_valid", 40'(want.core_valid), 40'(rsp_o.core_valid));
        check_field("usage_seconds", want.usage_seconds, rsp_o.usage_seconds);
        check_field("last", 40'(want.last), 40'(rsp_o.last));
      end
    end
  end

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------
  function automatic void push_request(cnra_pkg::req_type_e kind, logic [6:0] cores,
                                       logic [31:0] mem, logic [31:0] disk,
                                       logic [5:0] idx, logic [31:0] now);
    cnra_pkg::req_t r;
    r.req_type      = kind;
    r.core_count    = cores;
    r.memory_amount = mem;
    r.disk_amount   = disk;
    r.core_index    = idx;
    r.now_seconds   = now;
    pending_req_q.push_back(r);
  endfunction

  // mostly modest amounts against the total, sometimes anything
  function automatic logic [31:0] pick_amount(logic [31:0] total);
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $urandom_range(0, total / 8);
  endfunction

  function automatic logic [31:0] pick_total();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return $urandom_range(1024, 1 << 20);
    endcase
  endfunction

  // all four registers, back to back; only called while the block is idle
  task automatic write_config(logic [6:0] cores, logic [31:0] mem, logic [31:0] disk,
                              logic [6:0] slots);
    cnra_pkg::cfg_idx_e idx;
    logic [31:0]        val;
    int                 k;
    for (k = 0; k < 4; k++) begin
      idx = cnra_pkg::cfg_idx_e'(k);
      case (idx)
        cnra_pkg::CFG_TOTAL_CORES:  val = 32'(cores);
        cnra_pkg::CFG_TOTAL_MEMORY: val = mem;
        cnra_pkg::CFG_TOTAL_DISK:   val = disk;
        default:                    val = 32'(slots);
      endcase
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= val;
      load_totals(idx, val);
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // all driven, nothing owed, and the block given time to settle
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_req_q.size() != 0 || awaited_rsp_q.size() != 0 || start_i || busy_o);
    repeat (LATENCY) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------
  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    cnra_pkg::req_type_e kind;
    int unsigned         pick, n, phase_no, random_items, k;
    logic [31:0]         now_ctr;

    // state right after reset
    tot_cores = cnra_pkg::RST_TOTAL_CORES;
    tot_mem   = cnra_pkg::RST_TOTAL_MEMORY;
    tot_disk  = cnra_pkg::RST_TOTAL_DISK;
    tot_slots = cnra_pkg::RST_MAX_SLOTS;
    free_cores = core_span();
    free_mem   = tot_mem;
    free_disk  = tot_disk;
    free_slots = tot_slots;
    for (k = 0; k < NCORES; k++) begin
      core_free[k]  = 1'b1;
      core_stamp[k] = '0;
      core_usage[k] = '0;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part on the reset totals
    // every core, all memory and disk: the longest burst of grants
    push_request(cnra_pkg::REQ_ALLOC, 7'd64, cnra_pkg::RST_TOTAL_MEMORY,
                 cnra_pkg::RST_TOTAL_DISK, 6'd0, 32'd10);
    // the only slot is taken
    push_request(cnra_pkg::REQ_ALLOC, 7'd1, 32'd0, 32'd0, 6'd0, 32'd11);
    push_request(cnra_pkg::REQ_REL_CORE, 7'd0, 32'd0, 32'd0, 6'd63, 32'd1000);
    // same core again: already free, usage unchanged
    push_request(cnra_pkg::REQ_REL_CORE, 7'd0, 32'd0, 32'd0, 6'd63, 32'd5000);
    // oversized give-back caps at the totals
    push_request(cnra_pkg::REQ_REL_TOT, 7'd64, '1, '1, 6'd0, 32'd0);
    // counter says 64 free, map holds only one
    push_request(cnra_pkg::REQ_ALLOC, 7'd64, 32'd0, 32'd0, 6'd0, 32'd20);
    // time went backwards: elapsed wraps
    push_request(cnra_pkg::REQ_REL_CORE, 7'd0, 32'd0, 32'd0, 6'd5, 32'd5);
    push_request(cnra_pkg::REQ_REL_TOT, 7'd64, 32'd0, 32'd0, 6'd0, 32'd0);
    // granted with zero cores
    push_request(cnra_pkg::REQ_ALLOC, 7'd0, 32'd0, 32'd0, 6'd0, 32'd30);
    push_request(cnra_pkg::REQ_REL_TOT, 7'd0, 32'd0, 32'd0, 6'd0, 32'd0);
    // one unit too much memory, then disk
    push_request(cnra_pkg::REQ_ALLOC, 7'd0, cnra_pkg::RST_TOTAL_MEMORY + 1, 32'd0,
                 6'd0, 32'd31);
    push_request(cnra_pkg::REQ_ALLOC, 7'd0, 32'd0, cnra_pkg::RST_TOTAL_DISK + 1,
                 6'd0, 32'd32);
    push_request(cnra_pkg::REQ_ALLOC, 7'd3, 32'd0, 32'd0, 6'd0, 32'd40);
    push_request(cnra_pkg::REQ_REL_TOT, 7'd0, 32'd0, 32'd0, 6'd0, 32'd0);
    // more cores than the counter holds
    push_request(cnra_pkg::REQ_ALLOC, 7'd64, 32'd0, 32'd0, 6'd0, 32'd41);
    // unused type with every bit set: no result
    push_request(cnra_pkg::REQ_NONE, '1, '1, '1, '1, '1);
    push_request(cnra_pkg::REQ_REL_CORE, 7'd0, 32'd0, 32'd0, 6'd0, '1);
    push_request(cnra_pkg::REQ_REL_TOT, 7'd64, '1, '1, 6'd0, 32'd0);
    wait_drained();

    // random phases, each on its own totals; the first two take the extremes
    phase_no     = 0;
    random_items = 0;
    now_ctr      = '0;
    while (random_items < RANDOM_ITEMS) begin
      case (phase_no)
        0:       write_config(7'd1, '0, '0, 7'd1);
        1:       write_config(7'd64, '1, '1, 7'd64);
        default: write_config(($urandom_range(0, 3) == 0) ? 7'd64
                                                          : 7'($urandom_range(1, 64)),
                              pick_total(), pick_total(),
                              ($urandom_range(0, 3) == 0) ? 7'd1
                                                          : 7'($urandom_range(1, 64)));
      endcase
      // one phase runs without any sender gaps
      steady = (phase_no == 3);
      n = $urandom_range(20, 60);
      if (n > RANDOM_ITEMS - random_items) n = RANDOM_ITEMS - random_items;
      repeat (n) begin
        pick = $urandom_range(0, 99);
        if (pick < 45)      kind = cnra_pkg::REQ_ALLOC;
        else if (pick < 70) kind = cnra_pkg::REQ_REL_TOT;
        else if (pick < 95) kind = cnra_pkg::REQ_REL_CORE;
        else                kind = cnra_pkg::REQ_NONE;
        now_ctr = now_ctr + $urandom_range(0, 5000);
        push_request(kind,
                     ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 64))
                                                 : 7'($urandom_range(0, 4)),
                     pick_amount(tot_mem), pick_amount(tot_disk),
                     ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                 : 6'($urandom_range(0, core_span() - 1)),
                     ($urandom_range(0, 9) == 0) ? $urandom : now_ctr);
        random_items++;
      end
      wait_drained();
      phase_no++;
    end

    if (error_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
